// File: sv/spdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdc_pkg: shared definitions for the same-prime-divisor check
// Widths, microcode types, the control store and small helper functions.
// ----------------------------------------------------------------------------
package spdc_pkg;

  // Width of each input number.
  localparam int VALUE_WIDTH = 16;
  // Trial divisors reach a little past the square root of the largest number.
  localparam int DIV_W       = (VALUE_WIDTH + 1) / 2 + 1;
  // Running square of the trial divisor.
  localparam int SQ_W        = 2 * DIV_W;
  // Width of the distinct-prime counts (they saturate at all ones).
  localparam int CNT_W       = 3;
  // Bit counter of the serial divider.
  localparam int DCNT_W      = $clog2(VALUE_WIDTH + 1);
  // Microcode step counter.
  localparam int STEP_W      = 4;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [DIV_W-1:0]       divisor_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [STEP_W-1:0]      step_t;

  // Microcode addresses.
  localparam step_t S_IDLE   = STEP_W'(0);
  localparam step_t S_TEST   = STEP_W'(1);
  localparam step_t S_DIV_A  = STEP_W'(2);
  localparam step_t S_WAIT_A = STEP_W'(3);
  localparam step_t S_TAKE_A = STEP_W'(4);
  localparam step_t S_DIV_B  = STEP_W'(5);
  localparam step_t S_WAIT_B = STEP_W'(6);
  localparam step_t S_TAKE_B = STEP_W'(7);
  localparam step_t S_NEXT   = STEP_W'(8);
  localparam step_t S_FIN    = STEP_W'(9);
  localparam step_t S_RET    = STEP_W'(10);

  // Datapath action of one step.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_A,
    OP_TAKE_A,
    OP_DIV_B,
    OP_TAKE_B,
    OP_TALLY,
    OP_FINISH
  } op_t;

  // Jump condition of one step; when false the sequencer falls through.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOSTART,
    C_SQ_GT,
    C_BUSY,
    C_REM_ZERO,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // Control store.
  function automatic uword_t uc_rom(step_t step);
    uword_t w;
    case (step)
      S_IDLE:   w = '{op: OP_LOAD,   cond: C_NOSTART,  target: S_IDLE};
      S_TEST:   w = '{op: OP_NOP,    cond: C_SQ_GT,    target: S_FIN};
      S_DIV_A:  w = '{op: OP_DIV_A,  cond: C_NEVER,    target: S_IDLE};
      S_WAIT_A: w = '{op: OP_NOP,    cond: C_BUSY,     target: S_WAIT_A};
      S_TAKE_A: w = '{op: OP_TAKE_A, cond: C_REM_ZERO, target: S_DIV_A};
      S_DIV_B:  w = '{op: OP_DIV_B,  cond: C_NEVER,    target: S_IDLE};
      S_WAIT_B: w = '{op: OP_NOP,    cond: C_BUSY,     target: S_WAIT_B};
      S_TAKE_B: w = '{op: OP_TAKE_B, cond: C_REM_ZERO, target: S_DIV_B};
      S_NEXT:   w = '{op: OP_TALLY,  cond: C_ALWAYS,   target: S_TEST};
      S_FIN:    w = '{op: OP_FINISH, cond: C_OUT_BUSY, target: S_FIN};
      S_RET:    w = '{op: OP_NOP,    cond: C_ALWAYS,   target: S_IDLE};
      default:  w = '{op: OP_NOP,    cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

  // Increment that sticks at the largest count.
  function automatic count_t sat_inc(count_t c, logic en);
    count_t r;
    r = c;
    if (en && (c != '1)) begin
      r = c + count_t'(1);
    end
    return r;
  endfunction

endpackage

// File: sv/spdc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdc_if: channel interfaces of the same-prime-divisor check
// Valid/ready channels for the number pair and for the result.
// ----------------------------------------------------------------------------
interface spdc_in_if;
  logic                 valid;
  logic                 ready;
  spdc_pkg::value_t     num_a;
  spdc_pkg::value_t     num_b;

  modport source (output valid, output num_a, output num_b, input ready);
  modport sink   (input valid, input num_a, input num_b, output ready);
endinterface

interface spdc_out_if;
  logic                 valid;
  logic                 ready;
  logic                 same_primes;
  spdc_pkg::count_t     count_a;
  spdc_pkg::count_t     count_b;

  modport source (output valid, output same_primes, output count_a, output count_b,
                  input ready);
  modport sink   (input valid, input same_primes, input count_a, input count_b,
                  output ready);
endinterface

// File: sv/same_prime_divisor_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// same_prime_divisor_check: same distinct-prime-set test by trial division
// Factors two numbers under microcode control and compares their prime sets.
// ----------------------------------------------------------------------------
// Each input transaction carries two numbers, num_a and num_b, and yields one
// result transaction: same_primes is 1 when both numbers are divisible by
// exactly the same distinct primes, and count_a and count_b give how many
// distinct primes divide each number (saturating at 7). Zero is handled like
// one: no prime divisors. The block works on one pair at a time. A small
// microcode program steps a trial divisor d = 2, 3, 4, ... while d*d does not
// exceed the larger remaining cofactor; for each d a single shared serial
// divider (one quotient bit per cycle) tests both numbers and strips every
// power of d out of them. Each trial divisor costs one divider run per
// number, plus one more run for each extra power removed, so the divider
// sets how long a pair takes: shortest when both inputs are below 4, longest
// when one operand is a prime near the top of the 16-bit range and the
// other is a high power of two.
// A finished result sits in an output register, so the next pair is taken
// while the previous result still waits to be read.
// ----------------------------------------------------------------------------
module same_prime_divisor_check (
  input  logic          clk,
  input  logic          rst_n,
  spdc_in_if.sink       in_chan,
  spdc_out_if.source    out_chan
);

  // Sequencer.
  spdc_pkg::step_t      step_r, step_nxt;
  spdc_pkg::uword_t     uw;
  logic                 jump;

  // Datapath.
  spdc_pkg::value_t     na_r, na_nxt;
  spdc_pkg::value_t     nb_r, nb_nxt;
  spdc_pkg::divisor_t   d_r, d_nxt;
  logic [spdc_pkg::SQ_W-1:0] sq_r, sq_nxt;
  spdc_pkg::count_t     ca_r, ca_nxt;
  spdc_pkg::count_t     cb_r, cb_nxt;
  logic                 hit_a_r, hit_a_nxt;
  logic                 hit_b_r, hit_b_nxt;
  logic                 mism_r, mism_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_same_r, out_same_nxt;
  spdc_pkg::count_t     out_ca_r, out_ca_nxt;
  spdc_pkg::count_t     out_cb_r, out_cb_nxt;

  // Divider hookup.
  logic                 div_start;
  spdc_pkg::value_t     div_dividend;
  spdc_pkg::value_t     div_quo;
  spdc_pkg::divisor_t   div_rem;
  logic                 div_busy;

  logic                 in_take;
  logic                 out_busy;
  logic                 rem_zero;
  logic                 sq_above;
  logic                 fin_write;

  assign uw = spdc_pkg::uc_rom(step_r);

  assign in_chan.ready = (step_r == spdc_pkg::S_IDLE);
  assign in_take       = in_chan.valid && in_chan.ready;
  assign out_busy      = out_valid_r && !out_chan.ready;
  assign rem_zero      = (div_rem == '0);
  // The search ends once d*d passes both remaining cofactors.
  assign sq_above      = (sq_r > spdc_pkg::SQ_W'(na_r)) && (sq_r > spdc_pkg::SQ_W'(nb_r));
  assign fin_write     = (uw.op == spdc_pkg::OP_FINISH) && !out_busy;

  assign div_start    = (uw.op == spdc_pkg::OP_DIV_A) || (uw.op == spdc_pkg::OP_DIV_B);
  assign div_dividend = (uw.op == spdc_pkg::OP_DIV_B) ? nb_r : na_r;

  spdc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (d_r),
    .quotient  (div_quo),
    .remainder (div_rem),
    .busy      (div_busy)
  );

  // Jump condition of the current control word.
  always_comb begin
    case (uw.cond)
      spdc_pkg::C_NEVER:    jump = 1'b0;
      spdc_pkg::C_ALWAYS:   jump = 1'b1;
      spdc_pkg::C_NOSTART:  jump = !in_take;
      spdc_pkg::C_SQ_GT:    jump = sq_above;
      spdc_pkg::C_BUSY:     jump = div_busy;
      spdc_pkg::C_REM_ZERO: jump = rem_zero;
      spdc_pkg::C_OUT_BUSY: jump = out_busy;
      default:              jump = 1'b1;
    endcase
    step_nxt = jump ? uw.target : (step_r + spdc_pkg::STEP_W'(1));
  end

  // Datapath actions.
  always_comb begin
    na_nxt    = na_r;
    nb_nxt    = nb_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    ca_nxt    = ca_r;
    cb_nxt    = cb_r;
    hit_a_nxt = hit_a_r;
    hit_b_nxt = hit_b_r;
    mism_nxt  = mism_r;

    case (uw.op)
      spdc_pkg::OP_LOAD: begin
        if (in_take) begin
          // Zero has no prime divisors, just like one.
          na_nxt    = (in_chan.num_a == '0) ? spdc_pkg::value_t'(1) : in_chan.num_a;
          nb_nxt    = (in_chan.num_b == '0) ? spdc_pkg::value_t'(1) : in_chan.num_b;
          d_nxt     = spdc_pkg::divisor_t'(2);
          sq_nxt    = spdc_pkg::SQ_W'(4);
          ca_nxt    = '0;
          cb_nxt    = '0;
          hit_a_nxt = 1'b0;
          hit_b_nxt = 1'b0;
          mism_nxt  = 1'b0;
        end
      end
      spdc_pkg::OP_TAKE_A: begin
        if (rem_zero) begin
          na_nxt    = div_quo;
          hit_a_nxt = 1'b1;
        end
      end
      spdc_pkg::OP_TAKE_B: begin
        if (rem_zero) begin
          nb_nxt    = div_quo;
          hit_b_nxt = 1'b1;
        end
      end
      spdc_pkg::OP_TALLY: begin
        // A prime that divides only one of the numbers breaks the match.
        ca_nxt    = spdc_pkg::sat_inc(ca_r, hit_a_r);
        cb_nxt    = spdc_pkg::sat_inc(cb_r, hit_b_r);
        mism_nxt  = mism_r | (hit_a_r ^ hit_b_r);
        hit_a_nxt = 1'b0;
        hit_b_nxt = 1'b0;
        // (d+1)^2 = d^2 + 2d + 1.
        sq_nxt    = sq_r + (spdc_pkg::SQ_W'(d_r) << 1) + spdc_pkg::SQ_W'(1);
        d_nxt     = d_r + spdc_pkg::divisor_t'(1);
      end
      default: begin
      end
    endcase
  end

  // Result register. What is left of each number is one or a single prime
  // larger than every trial divisor used, so the leftovers must be equal.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_same_nxt  = out_same_r;
    out_ca_nxt    = out_ca_r;
    out_cb_nxt    = out_cb_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_write) begin
      out_valid_nxt = 1'b1;
      out_same_nxt  = !(mism_r || (na_r != nb_r));
      out_ca_nxt    = spdc_pkg::sat_inc(ca_r, na_r > spdc_pkg::value_t'(1));
      out_cb_nxt    = spdc_pkg::sat_inc(cb_r, nb_r > spdc_pkg::value_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= spdc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    na_r       <= na_nxt;
    nb_r       <= nb_nxt;
    d_r        <= d_nxt;
    sq_r       <= sq_nxt;
    ca_r       <= ca_nxt;
    cb_r       <= cb_nxt;
    hit_a_r    <= hit_a_nxt;
    hit_b_r    <= hit_b_nxt;
    mism_r     <= mism_nxt;
    out_same_r <= out_same_nxt;
    out_ca_r   <= out_ca_nxt;
    out_cb_r   <= out_cb_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.same_primes = out_same_r;
  assign out_chan.count_a     = out_ca_r;
  assign out_chan.count_b     = out_cb_r;

`ifndef SYNTHESIS
  // The running square tracks the trial divisor whenever the bound is tested.
  a_square_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == spdc_pkg::S_TEST) |->
      (sq_r == spdc_pkg::SQ_W'(d_r) * spdc_pkg::SQ_W'(d_r)))
    else $error("running square does not match trial divisor");

  // The divider only runs while the program waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (step_r == spdc_pkg::S_WAIT_A || step_r == spdc_pkg::S_WAIT_B))
    else $error("divider busy outside a wait step");

  // A new result appears only after the finishing step.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step_r == spdc_pkg::S_FIN))
    else $error("result written outside the finishing step");

  // Identical prime sets imply identical counts.
  a_same_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_same_r) |-> (out_ca_r == out_cb_r))
    else $error("matching prime sets with different counts");
`endif

endmodule

// File: sv/spdc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdc_div: serial restoring divider
// Produces one quotient bit per cycle while busy; busy rises after start and falls once every quotient bit is in.
// ----------------------------------------------------------------------------
module spdc_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  spdc_pkg::value_t       dividend,
  input  spdc_pkg::divisor_t     divisor,
  output spdc_pkg::value_t       quotient,
  output spdc_pkg::divisor_t     remainder,
  output logic                   busy
);

  logic                            busy_r, busy_nxt;
  logic [spdc_pkg::DCNT_W-1:0]     cnt_r, cnt_nxt;
  spdc_pkg::value_t                quo_r, quo_nxt;
  spdc_pkg::divisor_t              rem_r, rem_nxt;
  spdc_pkg::divisor_t              dsr_r, dsr_nxt;
  logic [spdc_pkg::DIV_W:0]        trial;
  logic [spdc_pkg::DIV_W:0]        diff;
  logic                            ge;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign trial = {rem_r, quo_r[spdc_pkg::VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = spdc_pkg::DCNT_W'(spdc_pkg::VALUE_WIDTH);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[spdc_pkg::VALUE_WIDTH-2:0], ge};
      rem_nxt = ge ? diff[spdc_pkg::DIV_W-1:0] : trial[spdc_pkg::DIV_W-1:0];
      cnt_nxt = cnt_r - spdc_pkg::DCNT_W'(1);
      if (cnt_r == spdc_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign busy      = busy_r;

endmodule
